// ===== hdl/kth_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_pkg
// Shared types and constants of the k-th largest tracker.
// ----------------------------------------------------------------------------
package kth_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 1;

  localparam logic [RANK_W-1:0] RANK_RESET   = 6'd1;
  localparam logic [ADDR_W-1:0] REG_KTH_RANK = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e_t;

  typedef enum logic {
    ST_READY  = 1'b0,
    ST_RESULT = 1'b1
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic insert;
    logic clear;
    logic query;
  } dp_cmd_t;

endpackage

// ===== hdl/kth_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_in_if
// Request channel: command and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kth_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   command;
  logic signed [kth_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// ===== hdl/kth_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_out_if
// Result channel: k-th value and enough flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kth_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [kth_pkg::VALUE_W-1:0] kth_value;
  logic                         enough;

  modport source (output valid, output kth_value, output enough, input ready);
  modport sink   (input valid, input kth_value, input enough, output ready);
endinterface

// ===== hdl/kth_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_regs
// APB-style configuration register file holding the query rank.
// ----------------------------------------------------------------------------
module kth_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kth_pkg::ADDR_W-1:0]    paddr,
  input  logic [kth_pkg::DATA_W-1:0]    pwdata,
  output logic [kth_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [kth_pkg::RANK_W-1:0]    kth_rank
);

  logic [kth_pkg::RANK_W-1:0] kth_rank_r;
  logic [kth_pkg::RANK_W-1:0] kth_rank_nxt;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    kth_rank_nxt = kth_rank_r;
    if (wr_en && paddr == kth_pkg::REG_KTH_RANK) begin
      kth_rank_nxt = pwdata[kth_pkg::RANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kth_rank_r <= kth_pkg::RANK_RESET;
    end else begin
      kth_rank_r <= kth_rank_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == kth_pkg::REG_KTH_RANK) begin
      prdata = {{(kth_pkg::DATA_W-kth_pkg::RANK_W){1'b0}}, kth_rank_r};
    end
  end

  assign kth_rank = kth_rank_r;

endmodule

// ===== hdl/kth_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_ctrl
// Controller: request handshake, command decode and result-holding state.
// ----------------------------------------------------------------------------
module kth_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output kth_pkg::dp_cmd_t dp_cmd
);

  kth_pkg::state_t state_r;
  kth_pkg::state_t state_nxt;
  logic            accept;
  logic            is_query;

  // result register frees up in the same cycle it is taken
  assign in_ready = (state_r == kth_pkg::ST_READY) || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    dp_cmd = '0;
    unique case (in_command)
      kth_pkg::CMD_INSERT: dp_cmd.insert = accept;
      kth_pkg::CMD_QUERY:  dp_cmd.query  = accept;
      kth_pkg::CMD_CLEAR:  dp_cmd.clear  = accept;
      default:             dp_cmd = '0;
    endcase
  end

  assign is_query = dp_cmd.query;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kth_pkg::ST_READY: begin
        if (is_query) begin
          state_nxt = kth_pkg::ST_RESULT;
        end
      end
      kth_pkg::ST_RESULT: begin
        if (out_ready && !is_query) begin
          state_nxt = kth_pkg::ST_READY;
        end
      end
      default: state_nxt = kth_pkg::ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kth_pkg::ST_READY;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      kth_pkg::ST_READY:  out_valid = 1'b0;
      kth_pkg::ST_RESULT: out_valid = 1'b1;
      default:            out_valid = 1'b0;
    endcase
  end

endmodule

// ===== hdl/kth_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_dp
// Datapath: sorted row of the largest values with parallel compare-and-shift
// insertion, held count and the registered query result.
// ----------------------------------------------------------------------------
module kth_dp #(
  parameter int TOP_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kth_pkg::dp_cmd_t                    dp_cmd,
  input  logic signed [kth_pkg::VALUE_W-1:0]  in_value,
  input  logic [kth_pkg::RANK_W-1:0]          kth_rank,
  output logic signed [kth_pkg::VALUE_W-1:0]  kth_value,
  output logic                                enough
);

  localparam int CNT_W = $clog2(TOP_DEPTH + 1);

  logic signed [kth_pkg::VALUE_W-1:0] row_r   [TOP_DEPTH];
  logic signed [kth_pkg::VALUE_W-1:0] row_nxt [TOP_DEPTH];
  logic [TOP_DEPTH-1:0]               take;
  logic [CNT_W-1:0]                   held_cnt_r;
  logic [CNT_W-1:0]                   held_cnt_nxt;
  logic signed [kth_pkg::VALUE_W-1:0] kth_value_r;
  logic signed [kth_pkg::VALUE_W-1:0] kth_value_nxt;
  logic                               enough_r;
  logic                               enough_nxt;
  logic signed [kth_pkg::VALUE_W-1:0] sel_value;
  logic [31:0]                        rank_ext;
  logic [31:0]                        cnt_ext;

  // a slot takes the new value or its upper neighbor once the value beats it;
  // equal values stay ahead, empty slots always take
  always_comb begin
    for (int i = 0; i < TOP_DEPTH; i++) begin
      take[i] = (32'(i) >= 32'(held_cnt_r)) || (in_value > row_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < TOP_DEPTH; i++) begin
      row_nxt[i] = row_r[i];
      if (dp_cmd.insert && take[i]) begin
        if (i == 0) begin
          row_nxt[i] = in_value;
        end else if (!take[i-1]) begin
          row_nxt[i] = in_value;
        end else begin
          row_nxt[i] = row_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TOP_DEPTH; i++) begin
      row_r[i] <= row_nxt[i];
    end
  end

  always_comb begin
    held_cnt_nxt = held_cnt_r;
    if (dp_cmd.clear) begin
      held_cnt_nxt = '0;
    end else if (dp_cmd.insert && held_cnt_r != CNT_W'(TOP_DEPTH)) begin
      held_cnt_nxt = held_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
    end else begin
      held_cnt_r <= held_cnt_nxt;
    end
  end

  assign rank_ext = 32'(kth_rank);
  assign cnt_ext  = 32'(held_cnt_r);

  always_comb begin
    sel_value = '0;
    for (int i = 0; i < TOP_DEPTH; i++) begin
      if (32'(i + 1) == rank_ext) begin
        sel_value = row_r[i];
      end
    end
  end

  always_comb begin
    enough_nxt    = enough_r;
    kth_value_nxt = kth_value_r;
    if (dp_cmd.query) begin
      enough_nxt = (rank_ext != 32'd0) && (rank_ext <= 32'(TOP_DEPTH)) &&
                   (cnt_ext >= rank_ext);
      kth_value_nxt = enough_nxt ? sel_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    kth_value_r <= kth_value_nxt;
    enough_r    <= enough_nxt;
  end

  assign kth_value = kth_value_r;
  assign enough    = enough_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_cnt_r) <= 32'(TOP_DEPTH))
    else $error("held count above row depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && dp_cmd.clear |=> held_cnt_r == '0)
    else $error("clear did not empty the row");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && dp_cmd.insert && held_cnt_r != CNT_W'(TOP_DEPTH)
      |=> held_cnt_r == $past(held_cnt_r) + CNT_W'(1))
    else $error("insert into non-full row did not grow count");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && dp_cmd.query |=> enough_r || kth_value_r == '0)
    else $error("query without enough values returned nonzero");

endmodule

// ===== hdl/kth_largest_tracker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_largest_tracker_top
// Tracks a multiset of signed 32-bit values and reports the k-th largest.
// ----------------------------------------------------------------------------
// Requests arrive on in_req (command, value): insert adds the value, query
// asks for the value of rank kth_rank, clear empties the set; command 3 is
// ignored. Only queries produce a result on out_res (kth_value, enough).
// The TOP_DEPTH largest values sit in a sorted register row; an insert
// compares against every slot at once and shifts the row in parallel;
// one request is taken per cycle unless a pending result stalls. A query
// result is registered and shows on out_res the cycle after acceptance.
// A waiting result is held in the output register; in_ready stays high as
// long as out_res is empty or taken in the same cycle, so a stalled
// receiver only blocks requests once a result is pending. Reset empties the
// set and sets kth_rank to 1; no clearing pass is needed. kth_rank is
// written via APB port address 0 by the user only while idle (not enforced).
// ----------------------------------------------------------------------------
module kth_largest_tracker_top #(
  parameter int TOP_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  kth_in_if.sink                        in_req,
  kth_out_if.source                     out_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kth_pkg::ADDR_W-1:0]    paddr,
  input  logic [kth_pkg::DATA_W-1:0]    pwdata,
  output logic [kth_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [kth_pkg::RANK_W-1:0] kth_rank;
  kth_pkg::dp_cmd_t           dp_cmd;

  kth_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .kth_rank (kth_rank)
  );

  kth_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_req.valid),
    .in_command (in_req.command),
    .in_ready   (in_req.ready),
    .out_valid  (out_res.valid),
    .out_ready  (out_res.ready),
    .dp_cmd     (dp_cmd)
  );

  kth_dp #(
    .TOP_DEPTH (TOP_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .in_value  (in_req.value),
    .kth_rank  (kth_rank),
    .kth_value (out_res.kth_value),
    .enough    (out_res.enough)
  );

endmodule
